FILE: src/bgnc_pkg.sv
// Package for the binary grid neighbor count core: sizes, register indexes,
// configuration and control structs, and the 3x3 neighbor judge function.
// Used by every other file of the block but bgnc_req_if; depends on nothing.
package bgnc_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = ADDR_W + 1;
   localparam int CFG_W = 11;
   localparam int ROW_W = 11;
   localparam int THR_W = 4;
   localparam int TOTAL_W = 21;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(1024);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1024);
   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(4);

   typedef enum logic [1:0] {
      REG_GRID_WIDTH = 2'd0,
      REG_GRID_HEIGHT = 2'd1,
      REG_NEIGHBOR_THRESHOLD = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] grid_width;
      logic [CFG_W-1:0] grid_height;
      logic [THR_W-1:0] neighbor_threshold;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic occupied;
      logic first_col;
      logic row_ge1;
      logic row_ge2;
      logic last_col;
      logic last_row;
   } cell_ctl_type;

   function automatic logic [1:0] pop3(input logic [2:0] v);
      pop3 = 2'(v[0]) + 2'(v[1]) + 2'(v[2]);
   endfunction

   // Columns hold bit 0 top, bit 1 middle, bit 2 bottom; the center is the
   // middle bit of the second column.
   function automatic logic judge(input logic [2:0] x, input logic [2:0] y,
                                  input logic [2:0] z, input logic [THR_W-1:0] thr);
      logic [3:0] sum;
      sum = 4'(pop3(x)) + 4'(pop3(y)) + 4'(pop3(z));
      judge = y[1] && ((sum - 4'd1) < thr);
   endfunction

endpackage

FILE: src/bgnc_req_if.sv
// Input channel of the grid neighbor count core: one occupancy bit per transfer.
// Depends on nothing.
interface bgnc_req_if;
   logic valid;
   logic ready;
   logic occupied;

   modport source (output valid, output occupied, input ready);
   modport sink (input valid, input occupied, output ready);
endinterface

FILE: src/bgnc_rsp_if.sv
// Result channel of the grid neighbor count core: the grid total per transfer.
// Depends on bgnc_pkg.
interface bgnc_rsp_if;
   import bgnc_pkg::*;
   logic valid;
   logic ready;
   logic [TOTAL_W-1:0] qualifying_total;

   modport source (output valid, output qualifying_total, input ready);
   modport sink (input valid, input qualifying_total, output ready);
endinterface

FILE: src/bgnc_csr.sv
// APB-style register file of the grid neighbor count core: width, height, threshold.
// Depends on bgnc_pkg.
module bgnc_csr
   import bgnc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic pready,
   output cfg_type cfg
);

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [THR_W-1:0] threshold_ff;
   reg_index_type index;
   logic write_en;

   assign index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready = 1'b1;
   assign write_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else if (write_en) begin
         case (index)
            REG_GRID_WIDTH: width_ff <= pwdata[CFG_W-1:0];
            REG_GRID_HEIGHT: height_ff <= pwdata[CFG_W-1:0];
            REG_NEIGHBOR_THRESHOLD: threshold_ff <= pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_GRID_WIDTH: prdata = CSR_DATA_W'(width_ff);
         REG_GRID_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         REG_NEIGHBOR_THRESHOLD: prdata = CSR_DATA_W'(threshold_ff);
         default: prdata = '0;
      endcase
   end

   assign cfg.grid_width = width_ff;
   assign cfg.grid_height = height_ff;
   assign cfg.neighbor_threshold = threshold_ff;

endmodule

FILE: src/bgnc_line_mem.sv
// Two-row line store of the grid neighbor count core: one word per column holding
// the row above and the row two above, registered read with write forwarding.
// Depends on bgnc_pkg.
module bgnc_line_mem
   import bgnc_pkg::*;
(
   input  logic clock,
   input  logic rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [1:0] wr_data,
   output logic [1:0] rd_data
);

   logic [1:0] mem [MAX_WIDTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A write landing on the same column at the same edge is passed straight through.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bgnc_window.sv
// 3x3 window, neighbor judges and saturating total of the grid neighbor count core.
// Depends on bgnc_pkg.
module bgnc_window
   import bgnc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  cell_ctl_type ctl,
   input  logic [1:0] rd_data,
   input  logic [THR_W-1:0] threshold,
   output logic up_masked,
   output logic [TOTAL_W-1:0] total_out
);

   logic [8:0] window_ff;
   logic [8:0] window_in;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic [2:0] column;
   logic [2:0] col_a;
   logic [2:0] col_b;
   logic [2:0] col_c;
   logic [3:0] hits;
   logic [2:0] hit_count;
   logic [TOTAL_W:0] total_sum;
   logic up2_masked;

   assign up_masked = ctl.row_ge1 && rd_data[0];
   assign up2_masked = ctl.row_ge2 && rd_data[1];
   assign column = {ctl.occupied, up_masked, up2_masked};

   always_comb begin
      if (ctl.first_col) begin
         window_in = {column, 6'd0};
      end else begin
         window_in = {column, window_ff[8:3]};
      end
      col_a = window_in[2:0];
      col_b = window_in[5:3];
      col_c = window_in[8:6];
      hits[0] = ctl.row_ge1 && !ctl.first_col && judge(col_a, col_b, col_c, threshold);
      hits[1] = ctl.row_ge1 && ctl.last_col && judge(col_b, col_c, 3'd0, threshold);
      hits[2] = ctl.last_row && !ctl.first_col
                && judge({1'b0, col_a[2:1]}, {1'b0, col_b[2:1]}, {1'b0, col_c[2:1]},
                         threshold);
      hits[3] = ctl.last_row && ctl.last_col
                && judge({1'b0, col_b[2:1]}, {1'b0, col_c[2:1]}, 3'd0, threshold);
      hit_count = 3'(hits[0]) + 3'(hits[1]) + 3'(hits[2]) + 3'(hits[3]);
      total_sum = {1'b0, total_ff} + (TOTAL_W+1)'(hit_count);
      if (total_sum > {1'b0, TOTAL_MAX}) begin
         total_out = TOTAL_MAX;
      end else begin
         total_out = total_sum[TOTAL_W-1:0];
      end
      if (ctl.last_col && ctl.last_row) begin
         total_in = '0;
      end else begin
         total_in = total_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         total_ff <= '0;
      end else if (advance) begin
         window_ff <= window_in;
         total_ff <= total_in;
      end
   end

endmodule

FILE: src/binary_grid_neighbor_count_threshold_core.sv
// Top level of the binary grid neighbor count core: raster positions, line store
// clearing, pipeline handshakes and the result register.
// Depends on bgnc_pkg, bgnc_req_if, bgnc_rsp_if, bgnc_csr, bgnc_line_mem, bgnc_window.
//
//   channel  direction  payload                  transfers
//   req      in         occupied (1 bit)         one per grid cell, raster order
//   rsp      out        qualifying_total (21)    one per grid, with the last cell
//   csr      in         APB registers 0, 4, 8    width, height, threshold
//
// One cell is taken each cycle while req.ready is high; a cell reads the line store
// at its accept edge, waits in stage s1 and is judged and written back as it leaves
// s1, which a full, stalled result register can delay. After reset the line store is
// cleared one column a cycle, all MAX_WIDTH columns, with req.ready low. After that,
// only a stalled result register with a second result waiting holds the input back.
module binary_grid_neighbor_count_threshold_core
   import bgnc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   bgnc_req_if.sink req,
   bgnc_rsp_if.source rsp,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic pready
);

   cfg_type cfg;
   logic clr_active_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic s1_valid_ff;
   cell_ctl_type s1_ctl_ff;
   cell_ctl_type s0_ctl;
   logic rsp_valid_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic [CNT_W-1:0] width_eff;
   logic [CFG_W-1:0] height_eff;
   logic accept;
   logic s1_emit;
   logic s1_advance;
   logic [1:0] rd_data;
   logic up_masked;
   logic [TOTAL_W-1:0] total_out;
   logic mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [1:0] mem_wr_data;

   bgnc_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   always_comb begin
      if (cfg.grid_width == '0) begin
         width_eff = CNT_W'(1);
      end else if (32'(cfg.grid_width) > MAX_WIDTH) begin
         width_eff = CNT_W'(MAX_WIDTH);
      end else begin
         width_eff = CNT_W'(cfg.grid_width);
      end
      if (cfg.grid_height == '0) begin
         height_eff = CFG_W'(1);
      end else begin
         height_eff = cfg.grid_height;
      end
   end

   assign s0_ctl.addr = col_ff;
   assign s0_ctl.occupied = req.occupied;
   assign s0_ctl.first_col = (col_ff == '0);
   assign s0_ctl.row_ge1 = (row_ff != '0);
   assign s0_ctl.row_ge2 = (row_ff > ROW_W'(1));
   assign s0_ctl.last_col = (({1'b0, col_ff} + CNT_W'(1)) >= width_eff);
   assign s0_ctl.last_row = (({1'b0, row_ff} + (ROW_W+1)'(1)) >= {1'b0, height_eff});

   assign s1_emit = s1_ctl_ff.last_col && s1_ctl_ff.last_row;
   assign s1_advance = s1_valid_ff && !(s1_emit && rsp_valid_ff && !rsp.ready);
   assign req.ready = !clr_active_ff && (!s1_valid_ff || s1_advance);
   assign accept = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(MAX_WIDTH - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (s0_ctl.last_col) begin
            col_ff <= '0;
            if (s0_ctl.last_row) begin
               row_ff <= '0;
            end else begin
               row_ff <= row_ff + ROW_W'(1);
            end
         end else begin
            col_ff <= col_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff <= s0_ctl;
      end
   end

   always_comb begin
      if (clr_active_ff) begin
         mem_wr_en = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = 2'b00;
      end else begin
         mem_wr_en = s1_advance;
         mem_wr_addr = s1_ctl_ff.addr;
         mem_wr_data = {up_masked, s1_ctl_ff.occupied};
      end
   end

   bgnc_line_mem u_line_mem (
      .clock(clock), .rd_en(accept), .rd_addr(col_ff), .wr_en(mem_wr_en),
      .wr_addr(mem_wr_addr), .wr_data(mem_wr_data), .rd_data(rd_data)
   );

   bgnc_window u_window (
      .clock(clock), .reset(reset), .advance(s1_advance), .ctl(s1_ctl_ff),
      .rd_data(rd_data), .threshold(cfg.neighbor_threshold), .up_masked(up_masked),
      .total_out(total_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_emit) begin
         rsp_total_ff <= total_out;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.qualifying_total = rsp_total_ff;

endmodule
